[rtl/mrut_pkg.sv]
// ----------------------------------------------------------------------------
// mrut_pkg
// shared types and constants for the mru ordered table unit
// ----------------------------------------------------------------------------
package mrut_pkg;

    localparam int KEY_W       = 64;
    localparam int NAME_W      = 32;
    localparam int TICK_W      = 32;
    localparam int POS_W       = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int DEPTH_DEF   = 16;
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 144;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        OP_TOUCH = 2'd0,
        OP_PIN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVAL    = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_M1,
        RD_POS
    } t_rsel;

    typedef enum logic [1:0] {
        WR_PIN,
        WR_SHIFT,
        WR_FRONT
    } t_wsel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FRONT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic              pinned;
        logic [TICK_W-1:0] tick;
    } t_entry;

    typedef struct packed {
        logic    latch;
        logic    ptr_clr;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    ptr_load_dest;
        logic    capture_pin;
        logic    mem_rd;
        t_rsel   rd_sel;
        logic    mem_wr;
        t_wsel   wr_sel;
        logic    set_status;
        t_status status;
        logic    ent_valid_set;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic key_zero;
        logic pos_ok;
        logic ptr_end;
        logic ptr_zero;
        logic ptr_one;
        logic dest_zero;
        logic key_match;
        logic out_stall;
    } t_stat;

endpackage

[rtl/mrut_ctrl.sv]
// ----------------------------------------------------------------------------
// mrut_ctrl
// sequencer for search, move-to-front shift and result hand-off
// ----------------------------------------------------------------------------
module mrut_ctrl
    import mrut_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  t_stat i_stat,
    output logic  o_s_tready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_TOUCH: begin
                        if (i_stat.key_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INVAL;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = S_SRCH_RD;
                        end
                    end
                    OP_PIN: begin
                        o_cmd.ptr_clr = 1'b1;
                        n_state       = S_SRCH_RD;
                    end
                    OP_READ: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.mem_rd        = 1'b1;
                            o_cmd.rd_sel        = RD_POS;
                            o_cmd.ent_valid_set = 1'b1;
                        end else begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOTFOUND;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_INVAL;
                        n_state          = S_DONE;
                    end
                endcase
            end
            S_SRCH_RD: begin
                if (i_stat.ptr_end) begin
                    if (i_stat.op == OP_PIN) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOTFOUND;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.ptr_load_dest = 1'b1;
                        n_state = i_stat.dest_zero ? S_FRONT : S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_sel = RD_PTR;
                    n_state      = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.key_match) begin
                    if (i_stat.op == OP_PIN) begin
                        o_cmd.mem_wr = 1'b1;
                        o_cmd.wr_sel = WR_PIN;
                        n_state      = S_DONE;
                    end else begin
                        o_cmd.capture_pin = 1'b1;
                        n_state = i_stat.ptr_zero ? S_FRONT : S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = RD_PTR_M1;
                n_state      = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.mem_wr  = 1'b1;
                o_cmd.wr_sel  = WR_SHIFT;
                o_cmd.ptr_dec = 1'b1;
                n_state = i_stat.ptr_one ? S_FRONT : S_SHIFT_RD;
            end
            S_FRONT: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.wr_sel = WR_FRONT;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/mrut_dp.sv]
// ----------------------------------------------------------------------------
// mrut_dp
// entry memory, search pointer, counters and output register
// ----------------------------------------------------------------------------
module mrut_dp
    import mrut_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [OUT_TUSER_W-1:0] o_m_tuser
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_entry r_mem [TABLE_DEPTH];

    logic [1:0]        r_op;
    logic [KEY_W-1:0]  r_key;
    logic [NAME_W-1:0] r_name;
    logic              r_pin;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ptr;
    logic [TICK_W-1:0] r_use_cnt;
    logic              r_new_pin;
    t_status           r_status;
    logic              r_ent_valid;
    t_entry            r_rd_data;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_ent_valid;
    t_entry               r_out_ent;
    logic [CNT_OUT_W-1:0] r_out_count;

    logic [CNT_W-1:0]  w_ptr_m1;
    logic [CNT_W-1:0]  w_dest;
    logic              w_full;
    logic [TICK_W-1:0] n_tick;
    logic [IDX_W-1:0]  w_raddr;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;

    assign w_ptr_m1 = r_ptr - 1'b1;
    assign w_full   = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_dest   = w_full ? CNT_W'(TABLE_DEPTH - 1) : r_count;
    assign n_tick   = r_use_cnt + 1'b1;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PTR:    w_raddr = r_ptr[IDX_W-1:0];
            RD_PTR_M1: w_raddr = w_ptr_m1[IDX_W-1:0];
            RD_POS:    w_raddr = IDX_W'(r_pos);
            default:   w_raddr = r_ptr[IDX_W-1:0];
        endcase
    end

    always_comb begin
        w_waddr = r_ptr[IDX_W-1:0];
        w_wdata = r_rd_data;
        case (i_cmd.wr_sel)
            WR_PIN: begin
                w_wdata.pinned = r_pin;
            end
            WR_SHIFT: begin
                w_wdata = r_rd_data;
            end
            WR_FRONT: begin
                w_waddr        = '0;
                w_wdata.key    = r_key;
                w_wdata.name   = r_name;
                w_wdata.pinned = r_new_pin;
                w_wdata.tick   = n_tick;
            end
            default: begin
                w_wdata = r_rd_data;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_s_tuser;
            r_key  <= i_s_tdata[63:0];
            r_name <= i_s_tdata[95:64];
            r_pin  <= i_s_tdata[96];
            r_pos  <= i_s_tdata[102:97];
        end
        if (i_cmd.ptr_load_dest) begin
            r_new_pin <= 1'b0;
        end else if (i_cmd.capture_pin) begin
            r_new_pin <= r_rd_data.pinned;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_use_cnt   <= '0;
            r_ptr       <= '0;
            r_status    <= ST_OK;
            r_ent_valid <= 1'b0;
        end else begin
            if (i_cmd.ptr_load_dest && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.mem_wr && i_cmd.wr_sel == WR_FRONT) begin
                r_use_cnt <= n_tick;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_load_dest) begin
                r_ptr <= w_dest;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end else if (i_cmd.ptr_dec) begin
                r_ptr <= w_ptr_m1;
            end
            if (i_cmd.latch) begin
                r_status    <= ST_OK;
                r_ent_valid <= 1'b0;
            end else begin
                if (i_cmd.set_status) begin
                    r_status <= i_cmd.status;
                end
                if (i_cmd.ent_valid_set) begin
                    r_ent_valid <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status    <= r_status;
            r_out_ent_valid <= r_ent_valid;
            r_out_ent       <= r_ent_valid ? r_rd_data : '0;
            r_out_count     <= CNT_OUT_W'(r_count);
        end
    end

    assign o_stat.op        = t_op'(r_op);
    assign o_stat.key_zero  = (r_key == '0);
    assign o_stat.pos_ok    = (CNT_OUT_W'(r_pos) < CNT_OUT_W'(r_count));
    assign o_stat.ptr_end   = (r_ptr == r_count);
    assign o_stat.ptr_zero  = (r_ptr == '0);
    assign o_stat.ptr_one   = (r_ptr == CNT_W'(1));
    assign o_stat.dest_zero = (w_dest == '0);
    assign o_stat.key_match = (r_rd_data.key == r_key);
    assign o_stat.out_stall = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {7'd0, r_out_count, r_out_ent.tick, r_out_ent.pinned,
                         r_out_ent.name, r_out_ent.key, r_out_ent_valid};

endmodule

[rtl/mru_ordered_table_unit.sv]
// ----------------------------------------------------------------------------
// mru_ordered_table_unit
// bounded table of keyed entries kept in most-recently-used order
// ----------------------------------------------------------------------------
// channel | direction | tdata                                  | tuser
// s       | in        | key, name, pin value, position         | opcode
// m       | out       | valid, key, name, pinned, tick, count  | status
//
// one item at a time; a search step is a memory read then a compare, and a
// shift step is a read then a write, on the entry memory.
// a new item is taken while the previous result waits in the output register.
// synchronous active-low reset empties the table and clears the tick.
// ----------------------------------------------------------------------------
module mru_ordered_table_unit
    import mrut_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // key[63:0], name_handle[95:64], pin_value[96], position[102:97]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // opcode[1:0]
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // entry_valid[0], out_key[64:1], out_name[96:65], out_pinned[97],
    // out_tick[129:98], entry_count[136:130]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [OUT_TUSER_W-1:0] o_m_tuser
);

    t_cmd  w_cmd;
    t_stat w_stat;

    mrut_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    mrut_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[136:130] <= CNT_OUT_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_m_tvalid && !i_m_tready))
        else $error("stalled result overwritten");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tuser == ST_OK))
        else $error("valid entry with error status");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second item taken while busy");

endmodule
